### rtl/ppt_pkg.sv
// ppt_pkg: shared types, constants and codes of the page permission table
// used by ppt_front, ppt_back and page_permission_table_core; no dependencies
package ppt_pkg;

   // address space geometry
   localparam int PAGE_OFFSET_BITS = 12;
   localparam int ADDRESS_BITS     = 32;
   localparam int PAGE_BITS        = ADDRESS_BITS - PAGE_OFFSET_BITS;
   localparam int SUM_BITS         = 34;

   // permission mask bits
   localparam logic [3:0] PERM_READ       = 4'h1;
   localparam logic [3:0] PERM_WRITE      = 4'h2;
   localparam logic [3:0] PERM_EXEC       = 4'h4;
   localparam logic [3:0] PERM_ACCESSIBLE = 4'h8;

   // request operation codes
   typedef enum logic [2:0] {
      OP_SET         = 3'd0,
      OP_CLEAR       = 3'd1,
      OP_CHECK_READ  = 3'd2,
      OP_CHECK_WRITE = 3'd3,
      OP_CHECK_EXEC  = 3'd4
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_UNMAPPED = 2'd1,
      STATUS_GUARD    = 2'd2,
      STATUS_DENIED   = 2'd3
   } status_type;

   // classified command kinds
   typedef enum logic [1:0] {
      KIND_NOP   = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_CHECK = 2'd2
   } kind_type;

   // command handed from front to back
   typedef struct packed {
      kind_type               kind;
      logic                   report;
      logic [3:0]             needed;
      logic [3:0]             new_mask;
      logic [PAGE_BITS-1:0]   first_page;
      logic [PAGE_BITS-1:0]   last_page;
   } cmd_type;

   // one result item
   typedef struct packed {
      status_type status;
      logic       any_found;
      logic       any_mismatch;
      logic       any_changed;
   } result_type;

   // back-end sequencer states
   typedef enum logic [1:0] {
      ST_SWEEP  = 2'd0,
      ST_IDLE   = 2'd1,
      ST_READ   = 2'd2,
      ST_UPDATE = 2'd3
   } state_type;

endpackage

### rtl/ppt_front.sv
// ppt_front: accepts requests, works out the page range or the checked page
// and holds classified commands in a two-entry queue; depends on ppt_pkg
module ppt_front
   import ppt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_address,
   input  logic [31:0] req_size,
   input  logic [3:0]  req_mask,
   input  logic        sweeping,
   output logic        cmd_valid,
   output cmd_type     cmd,
   input  logic        cmd_pop
);

   cmd_type                 queue_ff [2];
   logic                    wr_ptr_ff, wr_ptr_in;
   logic                    rd_ptr_ff, rd_ptr_in;
   logic [1:0]              count_ff, count_in;
   logic                    accept;
   cmd_type                 new_cmd;
   logic [ADDRESS_BITS-1:0] start;
   logic [SUM_BITS-1:0]     last_sum;
   logic [PAGE_BITS-1:0]    start_page;
   logic [PAGE_BITS-1:0]    end_page;

   // range end: start + size - 1, saturated at the top page; a zero size gives the start page
   always_comb begin
      start      = req_address[ADDRESS_BITS-1:0];
      start_page = start[ADDRESS_BITS-1:PAGE_OFFSET_BITS];
      last_sum   = {{(SUM_BITS-ADDRESS_BITS){1'b0}}, start}
                 + {{(SUM_BITS-32){1'b0}}, req_size} - SUM_BITS'(1);
      if (req_size == 32'd0) begin
         end_page = start_page;
      end else if (last_sum[SUM_BITS-1:ADDRESS_BITS] != '0) begin
         end_page = '1;
      end else begin
         end_page = last_sum[ADDRESS_BITS-1:PAGE_OFFSET_BITS];
      end
   end

   // classify the request
   always_comb begin
      new_cmd            = '0;
      new_cmd.first_page = start_page;
      new_cmd.last_page  = end_page;
      unique case (op_type'(req_operation))
         OP_SET: begin
            new_cmd.kind     = KIND_WRITE;
            new_cmd.report   = 1'b1;
            new_cmd.new_mask = req_mask;
         end
         OP_CLEAR: begin
            new_cmd.kind = KIND_WRITE;
         end
         OP_CHECK_READ: begin
            new_cmd.kind   = KIND_CHECK;
            new_cmd.needed = PERM_READ;
         end
         OP_CHECK_WRITE: begin
            new_cmd.kind   = KIND_CHECK;
            new_cmd.needed = PERM_WRITE;
         end
         OP_CHECK_EXEC: begin
            new_cmd.kind   = KIND_CHECK;
            new_cmd.needed = PERM_EXEC;
         end
         default: begin
            new_cmd.kind = KIND_NOP;
         end
      endcase
   end

   // queue control
   always_comb begin
      full      = (count_ff == 2'd2) || sweeping;
      accept    = push && !full;
      cmd_valid = (count_ff != 2'd0);
      cmd       = queue_ff[rd_ptr_ff];
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (cmd_pop && cmd_valid) ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, accept} - {1'b0, cmd_pop && cmd_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

### rtl/ppt_back.sv
// ppt_back: page mask memory, reset clearing sweep, page walker for range
// writes, permission checks and a two-entry result queue; depends on ppt_pkg
module ppt_back
   import ppt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   output logic       sweeping,
   output logic       empty,
   input  logic       pop,
   output result_type rsp
);

   logic [3:0]           mem [2**PAGE_BITS];
   logic [3:0]           rd_data_ff;
   logic [PAGE_BITS-1:0] rd_addr;
   logic                 mem_we;
   logic [PAGE_BITS-1:0] mem_waddr;
   logic [3:0]           mem_wdata;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [PAGE_BITS-1:0] sweep_ff, sweep_in;
   logic                 found_ff, found_in;
   logic                 mismatch_ff, mismatch_in;
   logic                 changed_ff, changed_in;

   result_type           res_queue_ff [2];
   logic                 res_wr_ptr_ff, res_rd_ptr_ff;
   logic [1:0]           res_count_ff, res_count_in;
   logic                 res_push;
   result_type           res_data;
   logic                 res_pop;
   logic                 hit;
   status_type           check_status;

   // permission check of the page just read
   always_comb begin
      hit = (rd_data_ff & (cmd_ff.needed | PERM_ACCESSIBLE)) != 4'd0;
      priority if (hit) begin
         check_status = STATUS_OK;
      end else if (rd_data_ff == 4'd0) begin
         check_status = STATUS_UNMAPPED;
      end else if ((rd_data_ff & PERM_ACCESSIBLE) == 4'd0) begin
         check_status = STATUS_GUARD;
      end else begin
         check_status = STATUS_DENIED;
      end
   end

   // sequencer: next state and datapath controls
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      page_in     = page_ff;
      sweep_in    = sweep_ff;
      found_in    = found_ff;
      mismatch_in = mismatch_ff;
      changed_in  = changed_ff;
      cmd_pop     = 1'b0;
      sweeping    = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = page_ff;
      mem_wdata   = cmd_ff.new_mask;
      rd_addr     = page_ff;
      res_push    = 1'b0;
      res_data    = '0;
      unique case (state_ff)
         ST_SWEEP: begin
            sweeping  = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = 4'd0;
            sweep_in  = sweep_ff + PAGE_BITS'(1);
            if (sweep_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rd_addr = cmd.first_page;
            if (cmd_valid && res_count_ff != 2'd2) begin
               cmd_pop     = 1'b1;
               cmd_in      = cmd;
               page_in     = cmd.first_page;
               found_in    = 1'b0;
               mismatch_in = 1'b0;
               changed_in  = 1'b0;
               if (cmd.kind == KIND_WRITE || cmd.kind == KIND_CHECK) begin
                  state_in = ST_UPDATE;
               end else begin
                  res_push = 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (cmd_ff.kind == KIND_CHECK) begin
               res_push        = 1'b1;
               res_data.status = check_status;
               state_in        = ST_IDLE;
            end else begin
               mem_we = 1'b1;
               if (rd_data_ff != 4'd0) begin
                  found_in = 1'b1;
                  if (rd_data_ff != cmd_ff.new_mask) begin
                     mismatch_in = 1'b1;
                  end
               end
               if (rd_data_ff != cmd_ff.new_mask) begin
                  changed_in = 1'b1;
               end
               if (page_ff == cmd_ff.last_page) begin
                  res_push              = 1'b1;
                  res_data.any_found    = found_in && cmd_ff.report;
                  res_data.any_mismatch = mismatch_in && cmd_ff.report;
                  res_data.any_changed  = changed_in && cmd_ff.report;
                  state_in              = ST_IDLE;
               end else begin
                  page_in  = page_ff + PAGE_BITS'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      page_ff     <= page_in;
      found_ff    <= found_in;
      mismatch_ff <= mismatch_in;
      changed_ff  <= changed_in;
   end

   // page mask memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // result queue
   always_comb begin
      empty        = (res_count_ff == 2'd0);
      res_pop      = pop && !empty;
      rsp          = res_queue_ff[res_rd_ptr_ff];
      res_count_in = res_count_ff + {1'b0, res_push} - {1'b0, res_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wr_ptr_ff <= 1'b0;
         res_rd_ptr_ff <= 1'b0;
         res_count_ff  <= 2'd0;
      end else begin
         if (res_push) begin
            res_wr_ptr_ff <= !res_wr_ptr_ff;
         end
         if (res_pop) begin
            res_rd_ptr_ff <= !res_rd_ptr_ff;
         end
         res_count_ff <= res_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         res_queue_ff[res_wr_ptr_ff] <= res_data;
      end
   end

endmodule

### rtl/page_permission_table_core.sv
// Page permission table: one 4-bit mask (read, write, execute, accessible)
// per 4 KiB page of a 32-bit space, held in a 2^20 x 4 single-write memory
// with a registered read port. Requests enter a two-entry command queue and
// results leave through a two-entry result queue, so either side may stall.
// After reset the table is cleared by a sweep of all 2^20 pages, one page
// per cycle, during which full stays high. In the back end a check is one
// memory read and one evaluation; a set or clear reads and then writes back
// each covered page in turn; an unknown operation is answered from idle
// with no memory access. Each request is first held in the command queue.
// Depends on ppt_pkg, ppt_front and ppt_back.
module page_permission_table_core
   import ppt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_address,
   input  logic [31:0] req_size,
   input  logic [3:0]  req_mask,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_status,
   output logic        rsp_any_found,
   output logic        rsp_any_mismatch,
   output logic        rsp_any_changed
);

   logic       cmd_valid;
   cmd_type    cmd;
   logic       cmd_pop;
   logic       sweeping;
   result_type rsp;

   // request side: classification and command queue
   ppt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_operation (req_operation),
      .req_address   (req_address),
      .req_size      (req_size),
      .req_mask      (req_mask),
      .sweeping      (sweeping),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   // execution side: memory, walker and result queue
   ppt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .sweeping  (sweeping),
      .empty     (empty),
      .pop       (pop),
      .rsp       (rsp)
   );

   // result fields
   assign rsp_status       = rsp.status;
   assign rsp_any_found    = rsp.any_found;
   assign rsp_any_mismatch = rsp.any_mismatch;
   assign rsp_any_changed  = rsp.any_changed;

endmodule
